>>> rtl/gmr_pkg.sv
// Shared constants and types for the GF(2) matrix rank counter.
`default_nettype none

package gmr_pkg;

  localparam int DIM_DEF        = 32;
  localparam int COUNT_BITS_DEF = 20;

  localparam int ROW_IN_W    = 32;
  localparam int RANK_W      = 6;
  localparam int COUNT_OUT_W = 20;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 72;
  localparam int M_PAD_W   = M_TDATA_W - RANK_W - 3 * COUNT_OUT_W;

  typedef struct packed {
    logic clear;
    logic update;
    logic full;
    logic minus_one;
  } tally_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/gmr_pivot_unit.sv
// One diagonal pivot step (search, swap, XOR-eliminate, rotate) over the whole matrix.
`default_nettype none

module gmr_pivot_unit #(
  parameter int  DIM = 32,
  localparam int PW  = $clog2(DIM)
) (
  input  logic           backward,
  input  logic [PW-1:0]  pivot,
  input  logic [DIM-1:0] rows_in  [DIM],
  output logic [DIM-1:0] rows_out [DIM]
);

  logic [DIM-1:0] in_span;
  logic [DIM-1:0] cand;
  logic [DIM-1:0] pick;
  logic [DIM-1:0] keep;
  logic [DIM-1:0] piv_row;
  logic [DIM-1:0] work [DIM];
  logic           need_swap;
  logic           has_pivot;

  // pivot row sits in lane 0, pivot column in bit 0
  always_comb begin
    logic [PW:0] sum;
    sum = '0;
    for (int i = 0; i < DIM; i++) begin
      sum = (PW+1)'(i) + {1'b0, pivot};
      if (i == 0) begin
        in_span[i] = 1'b0;
      end else if (backward) begin
        in_span[i] = (sum >= (PW+1)'(DIM));
      end else begin
        in_span[i] = (sum <= (PW+1)'(DIM - 1));
      end
      cand[i] = in_span[i] & rows_in[i][0];
    end
  end

  // forward: nearest row below; backward: nearest row above
  always_comb begin
    logic seen;
    seen = 1'b0;
    pick = '0;
    if (backward) begin
      for (int i = DIM - 1; i >= 0; i--) begin
        if (cand[i] && !seen) begin
          pick[i] = 1'b1;
          seen    = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < DIM; i++) begin
        if (cand[i] && !seen) begin
          pick[i] = 1'b1;
          seen    = 1'b1;
        end
      end
    end
  end

  assign need_swap = ~rows_in[0][0] & (|cand);
  assign has_pivot = rows_in[0][0] | (|cand);
  assign keep      = backward ? {DIM{1'b1}} : ({DIM{1'b1}} >> pivot);

  always_comb begin
    logic [DIM-1:0] sel;
    sel = '0;
    for (int i = 0; i < DIM; i++) begin
      if (pick[i]) begin
        sel = sel | rows_in[i];
      end
    end
    piv_row = need_swap ? sel : rows_in[0];
  end

  always_comb begin
    logic [DIM-1:0] base;
    base    = '0;
    work[0] = piv_row;
    for (int i = 1; i < DIM; i++) begin
      base = (need_swap && pick[i]) ? rows_in[0] : rows_in[i];
      if (has_pivot && in_span[i] && base[0]) begin
        work[i] = base ^ (piv_row & keep);
      end else begin
        work[i] = base;
      end
    end
  end

  // move to the next pivot: forward rotates up and right, backward down and left
  always_comb begin
    logic [DIM-1:0] w;
    w = '0;
    for (int i = 0; i < DIM; i++) begin
      if (backward) begin
        w           = work[(i + DIM - 1) % DIM];
        rows_out[i] = {w[DIM-2:0], w[DIM-1]};
      end else begin
        w           = work[(i + 1) % DIM];
        rows_out[i] = {w[0], w[DIM-1:1]};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/gmr_rank_tally.sv
// Saturating counts of full-rank, rank minus one and lower-rank matrices.
`default_nettype none

module gmr_rank_tally #(
  parameter int COUNT_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gmr_pkg::tally_ctrl_t    ctrl,
  output logic [COUNT_BITS-1:0]   full_count,
  output logic [COUNT_BITS-1:0]   minus_one_count,
  output logic [COUNT_BITS-1:0]   lower_count
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      full_count      <= '0;
      minus_one_count <= '0;
      lower_count     <= '0;
    end else if (ctrl.update) begin
      if (ctrl.full) begin
        if (full_count != '1) begin
          full_count <= full_count + 1'b1;
        end
      end else if (ctrl.minus_one) begin
        if (minus_one_count != '1) begin
          minus_one_count <= minus_one_count + 1'b1;
        end
      end else begin
        if (lower_count != '1) begin
          lower_count <= lower_count + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/gf2_matrix_rank_counter_top.sv
// Top level of the GF(2) matrix rank counter: row loader, pivot sequencer and result register.
// Rows 0 to DIM-2 of a matrix may arrive back to back. The last row starts the work:
// DIM-1 forward and DIM-1 backward pivot steps on the shared pivot unit, zero-row counting
// over all DIM rows, one count update, then the result register. s_tready is low while a
// matrix is being reduced or its result waits. rst clears the sequencer, row position,
// counts and m_tvalid; the matrix rows are not cleared.
`default_nettype none

module gf2_matrix_rank_counter_top #(
  parameter int DIM        = gmr_pkg::DIM_DEF,
  parameter int COUNT_BITS = gmr_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gmr_pkg::S_TDATA_W-1:0]  s_tdata,   // row_bits
  input  logic [0:0]                     s_tuser,   // start_stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // matrix_rank, full_rank_count, rank_31_count, low_rank_count, zero pad
  output logic [gmr_pkg::M_TDATA_W-1:0]  m_tdata
);

  import gmr_pkg::*;

  localparam int PW = $clog2(DIM);
  localparam int ZW = $clog2(DIM + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_FWD  = 3'd1;
  localparam logic [2:0] S_BWD  = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]            state;
  logic [PW-1:0]         row_position;
  logic [PW-1:0]         pivot;
  logic [ZW-1:0]         zeros;
  logic [DIM-1:0]        rows      [DIM];
  logic [DIM-1:0]        step_rows [DIM];
  logic                  in_acc;
  logic [PW-1:0]         row_pos_eff;
  logic                  last_row;
  logic [ZW-1:0]         rank_full;
  tally_ctrl_t           tally_ctrl;
  logic [COUNT_BITS-1:0] full_count;
  logic [COUNT_BITS-1:0] minus_one_count;
  logic [COUNT_BITS-1:0] lower_count;

  assign s_tready    = (state == S_LOAD);
  assign in_acc      = s_tvalid && s_tready;
  assign row_pos_eff = s_tuser[0] ? '0 : row_position;
  assign last_row    = (row_pos_eff == PW'(DIM - 1));
  assign rank_full   = ZW'(DIM) - zeros;

  gmr_pivot_unit #(
    .DIM (DIM)
  ) u_pivot (
    .backward (state == S_BWD),
    .pivot    (pivot),
    .rows_in  (rows),
    .rows_out (step_rows)
  );

  assign tally_ctrl.clear     = in_acc && s_tuser[0];
  assign tally_ctrl.update    = (state == S_DONE);
  assign tally_ctrl.full      = (zeros == '0);
  assign tally_ctrl.minus_one = (zeros == ZW'(1));

  gmr_rank_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (tally_ctrl),
    .full_count      (full_count),
    .minus_one_count (minus_one_count),
    .lower_count     (lower_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      row_position <= '0;
      pivot        <= '0;
      zeros        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (last_row) begin
              row_position <= '0;
              pivot        <= '0;
              state        <= S_FWD;
            end else begin
              row_position <= row_pos_eff + 1'b1;
            end
          end
        end
        S_FWD: begin
          if (pivot == PW'(DIM - 2)) begin
            pivot <= PW'(DIM - 1);
            state <= S_BWD;
          end else begin
            pivot <= pivot + 1'b1;
          end
        end
        S_BWD: begin
          if (pivot == PW'(1)) begin
            pivot <= '0;
            zeros <= '0;
            state <= S_CNT;
          end else begin
            pivot <= pivot - 1'b1;
          end
        end
        S_CNT: begin
          zeros <= zeros + ZW'(rows[0] == '0);
          if (pivot == PW'(DIM - 1)) begin
            state <= S_DONE;
          end else begin
            pivot <= pivot + 1'b1;
          end
        end
        S_DONE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      if (in_acc) begin
        for (int i = 0; i < DIM - 1; i++) begin
          rows[i] <= rows[i + 1];
        end
        rows[DIM-1] <= DIM'(s_tdata[ROW_IN_W-1:0]);
      end
    end else if (state == S_FWD || state == S_BWD) begin
      rows <= step_rows;
    end else if (state == S_CNT) begin
      for (int i = 0; i < DIM - 1; i++) begin
        rows[i] <= rows[i + 1];
      end
      rows[DIM-1] <= rows[0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!m_tvalid || m_tready)) begin
      m_tdata <= {{M_PAD_W{1'b0}},
                  COUNT_OUT_W'(lower_count),
                  COUNT_OUT_W'(minus_one_count),
                  COUNT_OUT_W'(full_count),
                  RANK_W'(rank_full)};
    end
  end

`ifndef SYNTHESIS
  a_last_row_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_row |=> state == S_FWD)
    else $error("last row of a matrix did not start reduction");

  a_zeros_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_CNT |-> zeros <= pivot)
    else $error("zero-row count exceeds rows examined");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_EMIT)
    else $error("result raised outside emit state");

  a_full_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && s_tuser[0]) |=> full_count >= $past(full_count))
    else $error("full-rank count dropped without a restart");
`endif

endmodule

`default_nettype wire
